### src/maf_pkg.sv
// Shared constants, types and state encodings for the moving average filter.
`default_nettype none

package maf_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int AVG_W     = 24;
  localparam int FRAC_W    = 8;
  localparam int WIN_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_HOLD
  } ctrl_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } div_state_t;

endpackage

`default_nettype wire

### src/maf_div.sv
// Serial restoring divider: signed running sum scaled by 256 over the fill count.
`default_nettype none

module maf_div #(
  parameter int DIVIDEND_W = 22
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [DIVIDEND_W-1:0]   dividend,
  input  wire logic [maf_pkg::WIN_W-1:0]      divisor,
  output logic                                done,
  output logic [maf_pkg::AVG_W-1:0]           quotient
);

  localparam int NUM_W = DIVIDEND_W + maf_pkg::FRAC_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int WIN_W = maf_pkg::WIN_W;
  localparam int AVG_W = maf_pkg::AVG_W;

  maf_pkg::div_state_t state, state_next;

  logic [CNT_W-1:0]      cnt;
  logic                  neg;
  logic [NUM_W-1:0]      quo;
  logic [WIN_W-1:0]      rem;
  logic [WIN_W-1:0]      divr;

  logic [DIVIDEND_W-1:0] mag;
  logic [WIN_W:0]        trial;
  logic [WIN_W:0]        diff;
  logic                  ge;
  logic [NUM_W+AVG_W-1:0] q_wide;
  logic [AVG_W-1:0]      q_low;

  assign mag   = dividend[DIVIDEND_W-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, divr};
  assign diff  = trial - {1'b0, divr};
  assign q_wide = {{AVG_W{1'b0}}, quo};
  assign q_low  = q_wide[AVG_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      maf_pkg::D_IDLE: begin
        if (start) state_next = maf_pkg::D_RUN;
      end
      maf_pkg::D_RUN: begin
        if (cnt == CNT_W'(1)) state_next = maf_pkg::D_FIX;
      end
      maf_pkg::D_FIX: begin
        state_next = maf_pkg::D_IDLE;
      end
      default: begin
        state_next = maf_pkg::D_IDLE;
      end
    endcase
  end

  always_comb begin
    done     = (state == maf_pkg::D_FIX);
    quotient = neg ? (~q_low + 1'b1) : q_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::D_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == maf_pkg::D_IDLE && start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (state == maf_pkg::D_RUN) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == maf_pkg::D_IDLE && start) begin
      neg  <= dividend[DIVIDEND_W-1];
      quo  <= {mag, {maf_pkg::FRAC_W{1'b0}}};
      rem  <= '0;
      divr <= divisor;
    end else if (state == maf_pkg::D_RUN) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
    end
  end

endmodule

`default_nettype wire

### src/moving_average_filter_top.sv
// Moving average filter top level: config registers, ring store, sequencer, output register.
//
// One sample per transaction; one average per sample. With averaging enabled a
// sample enters the window and the serial divider, which produces one quotient
// bit per cycle, forms the average; with averaging disabled the sample, scaled
// by 256, goes to the output register. The next sample is taken only once the
// result is loaded. The output register holds a finished result while the next
// sample is being worked on. Writing either register empties the window.
`default_nettype none

module moving_average_filter_top #(
  parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [maf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [maf_pkg::WIN_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [maf_pkg::AVG_W-1:0]     average
);

  localparam int WIN_W   = maf_pkg::WIN_W;
  localparam int AVG_W   = maf_pkg::AVG_W;
  localparam int FRAC_W  = maf_pkg::FRAC_W;
  localparam int WIN_MAX = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_MAX);
  localparam int ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W   = (ADDR_W + 1 > WIN_W) ? ADDR_W + 1 : WIN_W;

  maf_pkg::ctrl_state_t state, state_next;

  logic                    enable;
  logic [WIN_W-1:0]        win_len;
  logic [WIN_W-1:0]        fill_count;
  logic [ADDR_W-1:0]       oldest_slot;
  logic signed [SUM_W-1:0] running_sum;

  logic [SAMPLE_BITS-1:0]  store [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [AVG_W-1:0]        res;

  logic [WIN_W-1:0]        weff;
  logic                    full;
  logic [CMP_W-1:0]        oldest_inc;
  logic [CMP_W-1:0]        fill_ext;
  logic [ADDR_W-1:0]       oldest_next;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [SUM_W-1:0] sum_next;

  logic signed [SAMPLE_BITS+AVG_W-1:0] pass_ext;
  logic [AVG_W-1:0]        pass_val;

  logic                    out_load;
  logic                    div_start;
  logic                    div_done;
  logic [AVG_W-1:0]        div_q;

  always_comb begin
    if (win_len == '0) begin
      weff = WIN_W'(1);
    end else if (int'(win_len) > MAX_WINDOW) begin
      weff = WIN_W'(MAX_WINDOW);
    end else begin
      weff = win_len;
    end
  end

  assign full        = fill_count >= weff;
  assign oldest_inc  = CMP_W'(oldest_slot) + 1'b1;
  assign oldest_next = (oldest_inc == CMP_W'(weff)) ? '0 : oldest_inc[ADDR_W-1:0];
  assign fill_ext    = CMP_W'(fill_count);
  assign wr_addr     = full ? oldest_slot : fill_ext[ADDR_W-1:0];
  assign sum_next    = running_sum + SUM_W'(samp) - (full ? SUM_W'(rd_data) : SUM_W'(0));

  assign pass_ext = (SAMPLE_BITS + AVG_W)'(sample);
  assign pass_val = {pass_ext[AVG_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

  // registers and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      win_len     <= maf_pkg::WINDOW_RESET;
      fill_count  <= '0;
      oldest_slot <= '0;
      running_sum <= '0;
    end else if (cfg_wr_en && cfg_index == maf_pkg::REG_ENABLE) begin
      enable      <= cfg_data[0];
      fill_count  <= '0;
      oldest_slot <= '0;
      running_sum <= '0;
    end else if (cfg_wr_en && cfg_index == maf_pkg::REG_WINDOW) begin
      win_len     <= cfg_data;
      fill_count  <= '0;
      oldest_slot <= '0;
      running_sum <= '0;
    end else if (state == maf_pkg::S_UPDATE) begin
      running_sum <= sum_next;
      if (full) begin
        oldest_slot <= oldest_next;
      end else begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // ring store
  always_ff @(posedge clk) begin
    if (state == maf_pkg::S_UPDATE) begin
      store[wr_addr] <= samp;
    end
    rd_data <= store[oldest_slot];
  end

  always_comb begin
    state_next = state;
    case (state)
      maf_pkg::S_IDLE: begin
        if (in_valid) state_next = enable ? maf_pkg::S_UPDATE : maf_pkg::S_HOLD;
      end
      maf_pkg::S_UPDATE: begin
        state_next = maf_pkg::S_START;
      end
      maf_pkg::S_START: begin
        state_next = maf_pkg::S_DIVIDE;
      end
      maf_pkg::S_DIVIDE: begin
        if (div_done) state_next = maf_pkg::S_HOLD;
      end
      maf_pkg::S_HOLD: begin
        if (!out_valid || out_ready) state_next = maf_pkg::S_IDLE;
      end
      default: begin
        state_next = maf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == maf_pkg::S_IDLE);
    div_start = (state == maf_pkg::S_START);
    out_load  = (state == maf_pkg::S_HOLD) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= maf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp <= sample;
      res  <= pass_val;
    end else if (state == maf_pkg::S_DIVIDE && div_done) begin
      res <= div_q;
    end
    if (out_load) begin
      average <= res;
    end
  end

  maf_div #(
    .DIVIDEND_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (fill_count),
    .done     (div_done),
    .quotient (div_q)
  );

  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill_count <= weff)
    else $error("fill count beyond window");

  a_ring_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_slot != '0) |-> (fill_count == weff))
    else $error("ring pointer moved before window filled");

  a_done_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == maf_pkg::S_DIVIDE))
    else $error("divider finished outside divide state");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == maf_pkg::S_HOLD))
    else $error("output loaded outside hold state");

endmodule

`default_nettype wire
